[design/biw_pkg.sv]
`default_nettype none

package biw_pkg;

  // Item kinds carried on in_tuser
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd1;
  localparam int CFG_DATA_W = 9;

  // Field widths
  localparam int COORD_W = 8;
  localparam int PIXEL_W = 16;
  localparam int FLOW_W  = 16;

  // Stream widths (whole bytes)
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 32;

  // Reset size of the image in use
  localparam int RST_SIZE = 256;

endpackage

`default_nettype wire

[design/bilinear_image_warp.sv]
// A sample's result passes the stage 1, 2, 3 and output registers; loads give no result.
// Throughput: one item per cycle unless out_tready stalls it. The pixel store is split
// into four banks by column and row parity, so the whole 2x2 neighborhood is read at once.
// Reset (rst_n low, synchronous): pipeline emptied, sizes in use set to 256 (capped at the
// store size). The pixel store is not cleared; pixels are undefined until loaded.
`default_nettype none

module bilinear_image_warp
  import biw_pkg::*;
#(
  parameter int MAX_COLS  = 256,
  parameter int MAX_ROWS  = 256,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration write port
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // input items
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // col[7:0], row[15:8], pixel_value[31:16], flow_x[47:32], flow_y[63:48]
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  // kind[0]
  input  wire logic                  in_tuser,
  // result items
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // sampled_value[15:0], out_col[23:16], out_row[31:24]
  output logic [OUT_TDATA_W-1:0]     out_tdata
);

  localparam int CW   = $clog2(MAX_COLS);
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int BCW  = (CW > 1) ? CW - 1 : 1;
  localparam int BRW  = (RW > 1) ? RW - 1 : 1;
  localparam int BAW  = BCW + BRW;
  localparam int BANK_DEPTH = 1 << BAW;
  localparam int F    = FRAC_BITS;
  // wide enough for the full flow word before it is rescaled
  localparam int PW   = (F + 10 > FLOW_W) ? F + 10 : FLOW_W;
  localparam int UXW  = CW + F;
  localparam int UYW  = RW + F;
  localparam int EXW  = (PW > UXW + 1) ? PW : UXW + 1;
  localparam int EYW  = (PW > UYW + 1) ? PW : UYW + 1;
  localparam int FUP  = (F >= 8) ? F - 8 : 0;
  localparam int FDN  = (F < 8) ? 8 - F : 0;
  localparam int WW   = 2 * F + 1;
  localparam int PRW  = PIXEL_W + WW;
  localparam int ACW  = PRW + 2;
  localparam int RST_COLS = (MAX_COLS < RST_SIZE) ? MAX_COLS : RST_SIZE;
  localparam int RST_ROWS = (MAX_ROWS < RST_SIZE) ? MAX_ROWS : RST_SIZE;
  localparam logic [F:0]     ONE_W = (F + 1)'(1) << F;
  localparam logic [ACW-1:0] HALF  = ACW'(1) << (2 * F - 1);

  // input fields
  logic                      in_kind;
  logic [COORD_W-1:0]        in_col, in_row;
  logic [PIXEL_W-1:0]        in_pix;
  logic signed [FLOW_W-1:0]  in_flow_x, in_flow_y;

  assign in_kind   = in_tuser;
  assign in_col    = in_tdata[7:0];
  assign in_row    = in_tdata[15:8];
  assign in_pix    = in_tdata[31:16];
  assign in_flow_x = in_tdata[47:32];
  assign in_flow_y = in_tdata[63:48];

  // ---------------------------------------------------------------
  // Configuration: sizes kept as last valid index, clamped on write
  // ---------------------------------------------------------------
  logic [CW-1:0] cols_last_r;
  logic [RW-1:0] rows_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_last_r <= CW'(RST_COLS - 1);
      rows_last_r <= RW'(RST_ROWS - 1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_COLS_IN_USE: begin
          if (cfg_wdata == '0)
            cols_last_r <= '0;
          else if (32'(cfg_wdata) > 32'(MAX_COLS))
            cols_last_r <= CW'(MAX_COLS - 1);
          else
            cols_last_r <= CW'(cfg_wdata - CFG_DATA_W'(1));
        end
        CFG_ROWS_IN_USE: begin
          if (cfg_wdata == '0)
            rows_last_r <= '0;
          else if (32'(cfg_wdata) > 32'(MAX_ROWS))
            rows_last_r <= RW'(MAX_ROWS - 1);
          else
            rows_last_r <= RW'(cfg_wdata - CFG_DATA_W'(1));
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Pipeline valids and ready chain
  // ---------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s1_kind_r;
  logic rdy_out, rdy3, rdy2, rdy1;
  logic in_acc;

  assign rdy_out   = !out_v_r || out_tready;
  assign rdy3      = !s3_v_r || rdy_out;
  assign rdy2      = !s2_v_r || rdy3;
  assign rdy1      = !s1_v_r || (s1_kind_r == KIND_LOAD) || rdy2;
  assign in_tready = rdy1;
  assign in_acc    = in_tvalid && rdy1;

  // ---------------------------------------------------------------
  // Stage 1: displaced position, clamped into the image
  // ---------------------------------------------------------------
  logic signed [PW-1:0]  fsx, fsy, px, py;
  logic signed [EXW-1:0] px_e, hx_e;
  logic signed [EYW-1:0] py_e, hy_e;
  logic [UXW-1:0]        hi_x, ux;
  logic [UYW-1:0]        hi_y, uy;
  logic                  ld_ok;

  always_comb begin
    fsx  = (PW'(in_flow_x) <<< FUP) >>> FDN;
    fsy  = (PW'(in_flow_y) <<< FUP) >>> FDN;
    px   = $signed(PW'(in_col) << F) + fsx;
    py   = $signed(PW'(in_row) << F) + fsy;
    hi_x = UXW'(cols_last_r) << F;
    hi_y = UYW'(rows_last_r) << F;
    px_e = EXW'(px);
    py_e = EYW'(py);
    hx_e = $signed(EXW'(hi_x));
    hy_e = $signed(EYW'(hi_y));
    if (px_e[EXW-1])     ux = '0;
    else if (px_e > hx_e) ux = hi_x;
    else                  ux = UXW'(px_e);
    if (py_e[EYW-1])     uy = '0;
    else if (py_e > hy_e) uy = hi_y;
    else                  uy = UYW'(py_e);
    ld_ok = (32'(in_col) < 32'(MAX_COLS)) && (32'(in_row) < 32'(MAX_ROWS));
  end

  logic [COORD_W-1:0] s1_col_r, s1_row_r;
  logic [PIXEL_W-1:0] s1_pix_r;
  logic [UXW-1:0]     s1_ux_r;
  logic [UYW-1:0]     s1_uy_r;
  logic               s1_ldok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s1_kind_r <= KIND_LOAD;
    end else if (rdy1) begin
      s1_v_r    <= in_acc;
      s1_kind_r <= in_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r  <= in_col;
      s1_row_r  <= in_row;
      s1_pix_r  <= in_pix;
      s1_ux_r   <= ux;
      s1_uy_r   <= uy;
      s1_ldok_r <= ld_ok;
    end
  end

  // ---------------------------------------------------------------
  // Neighbors, weights and bank addresses from stage 1
  // ---------------------------------------------------------------
  logic [CW-1:0]  x0, x1, ld_x;
  logic [RW-1:0]  y0, y1, ld_y;
  logic [F-1:0]   fx, fy;
  logic [F:0]     wx0, wy0, wx1, wy1;
  logic [WW-1:0]  w00, w10, w01, w11;
  logic [BAW-1:0] rd_addr [4];
  logic [BAW-1:0] wr_addr;
  logic [1:0]     wr_bank;
  logic           wr_en;
  logic [CW-1:0]  csel, csh;
  logic [RW-1:0]  rsel, rsh;

  always_comb begin
    x0  = s1_ux_r[UXW-1:F];
    y0  = s1_uy_r[UYW-1:F];
    fx  = s1_ux_r[F-1:0];
    fy  = s1_uy_r[F-1:0];
    x1  = (x0 < cols_last_r) ? x0 + CW'(1) : cols_last_r;
    y1  = (y0 < rows_last_r) ? y0 + RW'(1) : rows_last_r;
    wx1 = {1'b0, fx};
    wy1 = {1'b0, fy};
    wx0 = ONE_W - wx1;
    wy0 = ONE_W - wy1;
    w00 = WW'(wx0) * WW'(wy0);
    w10 = WW'(wx1) * WW'(wy0);
    w01 = WW'(wx0) * WW'(wy1);
    w11 = WW'(wx1) * WW'(wy1);
    // bank {by, bx} holds pixels whose row parity is by and column parity is bx
    for (int b = 0; b < 4; b++) begin
      csel       = (x0[0] == b[0]) ? x0 : x1;
      rsel       = (y0[0] == b[1]) ? y0 : y1;
      csh        = csel >> 1;
      rsh        = rsel >> 1;
      rd_addr[b] = {BRW'(rsh), BCW'(csh)};
    end
    // load write
    ld_x    = CW'(s1_col_r);
    ld_y    = RW'(s1_row_r);
    wr_bank = {ld_y[0], ld_x[0]};
    wr_addr = {BRW'(ld_y >> 1), BCW'(ld_x >> 1)};
    wr_en   = s1_v_r && (s1_kind_r == KIND_LOAD) && s1_ldok_r;
  end

  // ---------------------------------------------------------------
  // Pixel store: four parity banks, registered read
  // ---------------------------------------------------------------
  logic [PIXEL_W-1:0] rd_q_r [4];

  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    logic [PIXEL_W-1:0] bank_mem [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 2'(gb)))
        bank_mem[wr_addr] <= s1_pix_r;
      if (rdy2)
        rd_q_r[gb] <= bank_mem[rd_addr[gb]];
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: pixel data with weights
  // ---------------------------------------------------------------
  logic [WW-1:0]      s2_w00_r, s2_w10_r, s2_w01_r, s2_w11_r;
  logic               s2_x0p_r, s2_x1p_r, s2_y0p_r, s2_y1p_r;
  logic [COORD_W-1:0] s2_col_r, s2_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      s2_v_r <= 1'b0;
    else if (rdy2)
      s2_v_r <= s1_v_r && (s1_kind_r == KIND_SAMPLE);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_w00_r <= w00;
      s2_w10_r <= w10;
      s2_w01_r <= w01;
      s2_w11_r <= w11;
      s2_x0p_r <= x0[0];
      s2_x1p_r <= x1[0];
      s2_y0p_r <= y0[0];
      s2_y1p_r <= y1[0];
      s2_col_r <= s1_col_r;
      s2_row_r <= s1_row_r;
    end
  end

  // pick each neighbor from its bank and weight it
  logic [PIXEL_W-1:0] p00, p10, p01, p11;
  logic [PRW-1:0]     m00, m10, m01, m11;

  always_comb begin
    p00 = rd_q_r[{s2_y0p_r, s2_x0p_r}];
    p10 = rd_q_r[{s2_y0p_r, s2_x1p_r}];
    p01 = rd_q_r[{s2_y1p_r, s2_x0p_r}];
    p11 = rd_q_r[{s2_y1p_r, s2_x1p_r}];
    m00 = PRW'(p00) * PRW'(s2_w00_r);
    m10 = PRW'(p10) * PRW'(s2_w10_r);
    m01 = PRW'(p01) * PRW'(s2_w01_r);
    m11 = PRW'(p11) * PRW'(s2_w11_r);
  end

  // ---------------------------------------------------------------
  // Stage 3: weighted products
  // ---------------------------------------------------------------
  logic [PRW-1:0]     s3_m00_r, s3_m10_r, s3_m01_r, s3_m11_r;
  logic [COORD_W-1:0] s3_col_r, s3_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      s3_v_r <= 1'b0;
    else if (rdy3)
      s3_v_r <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_m00_r <= m00;
      s3_m10_r <= m10;
      s3_m01_r <= m01;
      s3_m11_r <= m11;
      s3_col_r <= s2_col_r;
      s3_row_r <= s2_row_r;
    end
  end

  // sum, round half up, saturate
  logic [ACW-1:0]       acc;
  logic [ACW-2*F-1:0]   acc_sh;
  logic [PIXEL_W-1:0]   res;

  always_comb begin
    acc    = ACW'(s3_m00_r) + ACW'(s3_m10_r) + ACW'(s3_m01_r) + ACW'(s3_m11_r) + HALF;
    acc_sh = acc[ACW-1:2*F];
    res    = (acc_sh > (ACW-2*F)'({PIXEL_W{1'b1}})) ? {PIXEL_W{1'b1}} : PIXEL_W'(acc_sh);
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  logic [OUT_TDATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_v_r <= 1'b0;
    else if (rdy_out)
      out_v_r <= s3_v_r;
  end

  always_ff @(posedge clk) begin
    if (rdy_out)
      out_data_r <= {s3_row_r, s3_col_r, res};
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import biw_pkg::*;

  localparam int FRAC       = 8;           // flow is Q7.8, matching the block's weights
  localparam int ONE        = 1 << FRAC;
  localparam int PIPE_DEPTH = 3;
  localparam int STORE_COLS = 256;
  localparam int MAX_SIZE   = 256;
  localparam int MAX_SHOWN  = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic                kind;
    logic [7:0]          col;
    logic [7:0]          row;
    logic [15:0]         pixel;
    logic signed [15:0]  flow_x;
    logic signed [15:0]  flow_y;
  } warp_item_t;

  typedef struct packed {
    logic [15:0] value;
    logic [7:0]  col;
    logic [7:0]  row;
  } warp_result_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // col[7:0], row[15:8], pixel_value[31:16], flow_x[47:32], flow_y[63:48]
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  // kind[0]
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // sampled_value[15:0], out_col[23:16], out_row[31:24]
  logic [OUT_TDATA_W-1:0] out_tdata;

  bilinear_image_warp u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Mirror of the block: pixel store, size registers, pending work
  logic [15:0]  pix_store  [0:65535];
  bit           pix_loaded [0:65535];
  logic [8:0]   cols_reg = 9'(RST_SIZE);
  logic [8:0]   rows_reg = 9'(RST_SIZE);
  warp_item_t   pending_items[$];
  warp_result_t expected_samples[$];
  warp_item_t   cur_item;
  warp_result_t exp_r;
  bit           calm = 1'b0;
  int           send_gap = 0;
  int           recv_stall = 0;
  int           items_queued = 0;
  int           loads_applied = 0;
  int           samples_checked = 0;
  int           mismatch_count = 0;
  int           sizes_run = 1;

  function automatic int eff_size(logic [8:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIZE) return MAX_SIZE;
    return int'(v);
  endfunction

  function automatic logic [15:0] store_addr(int x, int y);
    return 16'(y * STORE_COLS + x);
  endfunction

  function automatic int clamp_fixed(int p, int size);
    if (p < 0) return 0;
    if (p > (size - 1) * ONE) return (size - 1) * ONE;
    return p;
  endfunction

  // Displaced, clamped position split into the 2x2 taps and their fractions
  function automatic void warp_taps(input logic [7:0] col, row,
                                    input logic signed [15:0] fx, fy,
                                    input int w, h,
                                    output int x0, x1, y0, y1, wx, wy);
    int ux, uy;
    ux = clamp_fixed((int'(col) << FRAC) + int'(fx), w);
    uy = clamp_fixed((int'(row) << FRAC) + int'(fy), h);
    x0 = ux >> FRAC;
    y0 = uy >> FRAC;
    wx = ux & (ONE - 1);
    wy = uy & (ONE - 1);
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
  endfunction

  function automatic logic [15:0] warped_value(warp_item_t it);
    int x0, x1, y0, y1, wx, wy;
    longint acc;
    warp_taps(it.col, it.row, it.flow_x, it.flow_y, eff_size(cols_reg), eff_size(rows_reg),
              x0, x1, y0, y1, wx, wy);
    acc = longint'(pix_store[store_addr(x0, y0)]) * (ONE - wx) * (ONE - wy)
        + longint'(pix_store[store_addr(x1, y0)]) * wx * (ONE - wy)
        + longint'(pix_store[store_addr(x0, y1)]) * (ONE - wx) * wy
        + longint'(pix_store[store_addr(x1, y1)]) * wx * wy;
    // round half up, then saturate
    acc = (acc + (longint'(1) << (2 * FRAC - 1))) >>> (2 * FRAC);
    return (acc > 64'hFFFF) ? 16'hFFFF : acc[15:0];
  endfunction

  // Apply an accepted item to the mirror
  task automatic commit_item(warp_item_t it);
    warp_result_t r;
    if (it.kind == KIND_LOAD) begin
      pix_store[{it.row, it.col}] = it.pixel;
      loads_applied++;
    end else begin
      r.value = warped_value(it);
      r.col   = it.col;
      r.row   = it.row;
      expected_samples.push_back(r);
    end
  endtask

  // Stimulus building
  task automatic queue_load(int x, int y, logic [15:0] value);
    warp_item_t it;
    it.kind   = KIND_LOAD;
    it.col    = 8'(x);
    it.row    = 8'(y);
    it.pixel  = value;
    it.flow_x = 16'($urandom_range(0, 65535));
    it.flow_y = 16'($urandom_range(0, 65535));
    pix_loaded[store_addr(x, y)] = 1'b1;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic ensure_pixel(int x, int y);
    if (!pix_loaded[store_addr(x, y)])
      queue_load(x, y, 16'($urandom_range(0, 65535)));
  endtask

  // Loads any tap never written, so no undefined pixel is ever read
  task automatic queue_sample(logic [7:0] c, r, logic signed [15:0] fx, fy);
    warp_item_t it;
    int x0, x1, y0, y1, wx, wy;
    warp_taps(c, r, fx, fy, eff_size(cols_reg), eff_size(rows_reg), x0, x1, y0, y1, wx, wy);
    ensure_pixel(x0, y0);
    ensure_pixel(x1, y0);
    ensure_pixel(x0, y1);
    ensure_pixel(x1, y1);
    it.kind   = KIND_SAMPLE;
    it.col    = c;
    it.row    = r;
    it.pixel  = 16'($urandom_range(0, 65535));
    it.flow_x = fx;
    it.flow_y = fy;
    pending_items.push_back(it);
    items_queued++;
  endtask

  function automatic logic signed [15:0] random_flow();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'(($urandom_range(0, 8) - 4) * ONE + ($urandom_range(0, 1) ? ONE / 2 : 0));
      default: return 16'(int'($urandom_range(0, 6 * ONE)) - 3 * ONE);
    endcase
  endfunction

  function automatic int random_coord(int size);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, size - 1);
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_samples.size() != 0);
    // loads leave no trace on the output, let the pipe empty
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_COLS_IN_USE: cols_reg = value;
      CFG_ROWS_IN_USE: rows_reg = value;
      default: ;
    endcase
  endtask

  // One image size: mostly samples over loaded pixels, with stray loads in between
  task automatic run_phase(logic [8:0] cols, logic [8:0] rows, int n, bit quiet);
    int target;
    wait_idle();
    write_reg(CFG_COLS_IN_USE, cols);
    write_reg(CFG_ROWS_IN_USE, rows);
    calm = quiet;
    sizes_run++;
    target = items_queued + n;
    while (items_queued < target) begin
      if ($urandom_range(0, 9) < 3)
        queue_load(random_coord(eff_size(cols_reg)), random_coord(eff_size(rows_reg)),
                   16'($urandom_range(0, 65535)));
      else
        queue_sample(8'(random_coord(eff_size(cols_reg))), 8'(random_coord(eff_size(rows_reg))),
                     random_flow(), random_flow());
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        commit_item(cur_item);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {cur_item.flow_y, cur_item.flow_x, cur_item.pixel,
                        cur_item.row, cur_item.col};
          in_tuser  <= cur_item.kind;
          if (!calm && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 15);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      recv_stall = $urandom_range(0, 14);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("%0t: result with none pending: value %h col %0d row %0d", $realtime,
                   out_tdata[15:0], out_tdata[23:16], out_tdata[31:24]);
      end else begin
        exp_r = expected_samples.pop_front();
        samples_checked++;
        if (out_tdata[15:0] !== exp_r.value || out_tdata[23:16] !== exp_r.col ||
            out_tdata[31:24] !== exp_r.row) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display("%0t: sample mismatch: expected value %h col %0d row %0d, got %h %0d %0d",
                     $realtime, exp_r.value, exp_r.col, exp_r.row,
                     out_tdata[15:0], out_tdata[23:16], out_tdata[31:24]);
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("[bilinear_image_warp] ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, at the reset size of 256 x 256
    queue_load(0, 0, 16'hFFFF);
    queue_load(1, 0, 16'h0000);
    queue_load(0, 1, 16'h0000);
    queue_load(1, 1, 16'hFFFF);
    queue_sample(8'd0, 8'd0, 16'sh0000, 16'sh0000);   // exact pixel
    queue_sample(8'd0, 8'd0, 16'sh0080, 16'sh0000);   // half weight, rounds up
    queue_sample(8'd0, 8'd0, 16'sh0080, 16'sh0080);   // all four taps
    queue_sample(8'd0, 8'd0, 16'sh8000, 16'sh8000);   // negative position, first column/row
    queue_sample(8'd0, 8'd0, 16'sh0001, 16'sh00FF);   // smallest and largest fraction
    queue_load(255, 255, 16'h8001);
    queue_sample(8'd255, 8'd255, 16'sh0000, 16'sh0000); // right/bottom taps clamp
    queue_sample(8'd255, 8'd255, 16'sh7FFF, 16'sh7FFF); // far past the edge
    queue_sample(8'd128, 8'd128, 16'sh8000, 16'sh7FFF);
    queue_sample(8'd0, 8'd0, 16'sh7FFF, 16'sh0000);

    // Random, over several image sizes; each phase starts with the block drained
    run_phase(9'd5,   9'd3,   110, 1'b0);
    wait_idle();
    write_reg(CFG_SPARE_A, 9'h1AA);                   // unused indexes are ignored
    write_reg(CFG_SPARE_B, 9'h055);
    run_phase(9'd0,   9'd0,   60,  1'b0);             // zero size acts as 1 x 1
    run_phase(9'd511, 9'd2,   110, 1'b0);             // oversize width is capped
    run_phase(9'd1,   9'd511, 90,  1'b0);
    run_phase(9'd256, 9'd256, 60,  1'b0);
    run_phase(9'd9,   9'd7,   120, 1'b1);             // no idling to the end
    wait_idle();

    mismatch_count += expected_samples.size();
    $display("Warped %0d samples over %0d pixel loads across %0d image sizes,",
             samples_checked, loads_applied, sizes_run);
    $display("with edge clamping, zero and oversize size registers and random stalls.");
    if (mismatch_count == 0) begin
      $display("[bilinear_image_warp] OK");
    end else begin
      $display("[bilinear_image_warp] ERROR");
    end
    $finish;
  end

endmodule
